/* hw/rtl/i2r_pkg.sv */
// ----------------------------------------------------------------------------
// I420 to RGBA converter: shared package
// Defaults, register map, coefficients, queue item control and settle states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2r_pkg;

  // Default frame limits
  localparam int unsigned MAX_WIDTH_DEF  = 640;
  localparam int unsigned MAX_HEIGHT_DEF = 480;

  // Configuration register map
  localparam int unsigned CFG_DATA_W    = 10;
  localparam int unsigned WIDTH_REG_W   = 10;
  localparam int unsigned HEIGHT_REG_W  = 9;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 10'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 9'd480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Fixed result field widths
  localparam int unsigned ROW_OUT_W = 9;
  localparam int unsigned COL_OUT_W = 10;

  // BT.601 full range, 8.8 fixed point
  localparam int unsigned COEF_RV = 359;
  localparam int unsigned COEF_GU = 88;
  localparam int unsigned COEF_GV = 183;
  localparam int unsigned COEF_BU = 454;
  localparam logic [7:0]  ALPHA   = 8'hFF;
  localparam logic [7:0]  PIX_MAX = 8'd255;

  // Decoupling queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    ITEM_Y = 2'd0,
    ITEM_U = 2'd1,
    ITEM_V = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic       frame_last;
  } item_ctrl_t;

  // Front settle sequence after reset or a register write
  typedef enum logic [2:0] {
    ST_SIZE  = 3'd0,
    ST_MUL   = 3'd1,
    ST_BOUND = 3'd2,
    ST_DIV   = 3'd3,
    ST_WAIT  = 3'd4,
    ST_BASE  = 3'd5,
    ST_RUN   = 3'd6
  } settle_st_t;

  // Index bits for a store of the given depth, never below one
  function automatic int unsigned idx_bits(input int unsigned depth);
    int unsigned n;
    n = (depth > 1) ? $clog2(depth) : 1;
    return n;
  endfunction

endpackage

/* hw/rtl/i2r_div.sv */
// ----------------------------------------------------------------------------
// I420 to RGBA converter: restoring divider
// One quotient bit per cycle; used to rebuild the chroma block position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2r_div #(
  parameter int unsigned N_W = 19,
  parameter int unsigned D_W = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quot,
  output logic [D_W-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   quot_r;
  logic [D_W-1:0]   rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [D_W:0]     trial;
  logic             take;

  assign trial = {rem_r, quot_r[N_W-1]};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= CNT_W'(N_W);
      end else if (busy_r) begin
        cnt_r  <= cnt_r - CNT_W'(1);
        done_r <= cnt_r == CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      quot_r <= {quot_r[N_W-2:0], take};
      rem_r  <= take ? D_W'(trial - {1'b0, divisor}) : trial[D_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

/* hw/rtl/i2r_queue.sv */
// ----------------------------------------------------------------------------
// I420 to RGBA converter: decoupling queue
// Small register FIFO between the classifying front and the pixel back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2r_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = i2r_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int unsigned PTR_W = i2r_pkg::idx_bits(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> !empty)
    else $error("pushed word not held");
`endif

endmodule

/* hw/rtl/i2r_front.sv */
// ----------------------------------------------------------------------------
// I420 to RGBA converter: front end
// Holds the size registers, tracks the byte position and classifies each
// word as a Y write, a U write or a V quad for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2r_front #(
  parameter int unsigned MAX_WIDTH  = i2r_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = i2r_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned W_W  = $clog2(MAX_WIDTH + 1),
  localparam int unsigned LA_W = i2r_pkg::idx_bits(MAX_WIDTH * MAX_HEIGHT),
  localparam int unsigned CA_W = i2r_pkg::idx_bits((MAX_WIDTH / 2) * (MAX_HEIGHT / 2)),
  localparam int unsigned BR_W = i2r_pkg::idx_bits(MAX_HEIGHT / 2),
  localparam int unsigned BC_W = i2r_pkg::idx_bits(MAX_WIDTH / 2)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_frame_start,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [i2r_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                  push,
  output i2r_pkg::item_ctrl_t   push_ctrl,
  output logic [7:0]            push_data,
  output logic [LA_W-1:0]       push_luma,
  output logic [CA_W-1:0]       push_chroma,
  output logic [BR_W-1:0]       push_brow,
  output logic [BC_W-1:0]       push_bcol,
  input  logic                  q_full,
  output logic [W_W-1:0]        frame_w
);

  localparam int unsigned H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EW    = (W_W > i2r_pkg::WIDTH_REG_W) ? W_W : i2r_pkg::WIDTH_REG_W;
  localparam int unsigned EH    = (H_W > i2r_pkg::HEIGHT_REG_W) ? H_W : i2r_pkg::HEIGHT_REG_W;
  localparam int unsigned LN_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT * 3 / 2 + 1);
  localparam int unsigned D_W   = $clog2(MAX_WIDTH / 2 + 1);

  i2r_pkg::settle_st_t st_r, st_nxt;

  logic [i2r_pkg::WIDTH_REG_W-1:0]  width_r;
  logic [i2r_pkg::HEIGHT_REG_W-1:0] height_r;
  logic [W_W-1:0]   w_eff_r;
  logic [H_W-1:0]   h_eff_r;
  logic [LN_W-1:0]  luma_n_r;
  logic [POS_W-1:0] uv_bound_r;
  logic [POS_W-1:0] total_r;
  logic [POS_W-1:0] pos_r;
  logic             active_r;
  logic [BR_W-1:0]  brow_r;
  logic [BC_W-1:0]  bcol_r;
  logic [LA_W-1:0]  tl_r;

  logic [EW-1:0]    w_ext, w_even, w_lim;
  logic [EH-1:0]    h_ext, h_even, h_lim;
  logic             div_start, div_done;
  logic [POS_W-1:0] div_num, div_quot;
  logic [D_W-1:0]   div_rem;

  logic             acc, act, hit, last, is_y, is_u, bcol_wrap;
  logic [POS_W-1:0] pos, pos_inc, u_off, v_off;

  // Sizes in use: even, clamped to 2..MAX
  always_comb begin
    w_ext  = EW'(width_r);
    w_even = w_ext & ~EW'(1);
    if (w_even < EW'(2)) w_lim = EW'(2);
    else if (w_even > EW'(MAX_WIDTH)) w_lim = EW'(MAX_WIDTH) & ~EW'(1);
    else w_lim = w_even;
    h_ext  = EH'(height_r);
    h_even = h_ext & ~EH'(1);
    if (h_even < EH'(2)) h_lim = EH'(2);
    else if (h_even > EH'(MAX_HEIGHT)) h_lim = EH'(MAX_HEIGHT) & ~EH'(1);
    else h_lim = h_even;
  end

  // Settle sequence
  always_comb begin
    st_nxt    = st_r;
    div_start = 1'b0;
    unique case (st_r)
      i2r_pkg::ST_SIZE:  st_nxt = i2r_pkg::ST_MUL;
      i2r_pkg::ST_MUL:   st_nxt = i2r_pkg::ST_BOUND;
      i2r_pkg::ST_BOUND: st_nxt = i2r_pkg::ST_DIV;
      i2r_pkg::ST_DIV: begin
        div_start = 1'b1;
        st_nxt    = i2r_pkg::ST_WAIT;
      end
      i2r_pkg::ST_WAIT:  if (div_done) st_nxt = i2r_pkg::ST_BASE;
      i2r_pkg::ST_BASE:  st_nxt = i2r_pkg::ST_RUN;
      i2r_pkg::ST_RUN:   st_nxt = i2r_pkg::ST_RUN;
      default:           st_nxt = i2r_pkg::ST_SIZE;
    endcase
    if (cfg_we) st_nxt = i2r_pkg::ST_SIZE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= i2r_pkg::ST_SIZE;
    else st_r <= st_nxt;
  end

  // Block position is rebuilt from the byte position on a size change
  assign div_num = (pos_r >= uv_bound_r && pos_r < total_r) ? pos_r - uv_bound_r : '0;

  i2r_div #(
    .N_W(POS_W),
    .D_W(D_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (D_W'(w_eff_r >> 1)),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Classification of the current word
  always_comb begin
    acc       = in_valid && !in_stall;
    act       = in_frame_start || active_r;
    pos       = in_frame_start ? '0 : pos_r;
    pos_inc   = pos + POS_W'(1);
    hit       = act && (pos < total_r);
    last      = hit && (pos_inc == total_r);
    is_y      = pos < POS_W'(luma_n_r);
    is_u      = pos < uv_bound_r;
    u_off     = pos - POS_W'(luma_n_r);
    v_off     = pos - uv_bound_r;
    bcol_wrap = ({1'b0, bcol_r} + (BC_W + 1)'(1)) == (BC_W + 1)'(w_eff_r >> 1);
  end

  assign in_stall = (st_r != i2r_pkg::ST_RUN) || q_full;
  assign push     = acc && hit;

  always_comb begin
    push_ctrl.frame_last = last;
    if (is_y) push_ctrl.kind = i2r_pkg::ITEM_Y;
    else if (is_u) push_ctrl.kind = i2r_pkg::ITEM_U;
    else push_ctrl.kind = i2r_pkg::ITEM_V;
  end

  assign push_data   = in_data_byte;
  assign push_luma   = is_y ? LA_W'(pos) : tl_r;
  assign push_chroma = is_u ? CA_W'(u_off) : CA_W'(v_off);
  assign push_brow   = brow_r;
  assign push_bcol   = bcol_r;
  assign frame_w     = w_eff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= i2r_pkg::WIDTH_RST;
      height_r <= i2r_pkg::HEIGHT_RST;
      active_r <= 1'b0;
      pos_r    <= '0;
      brow_r   <= '0;
      bcol_r   <= '0;
      tl_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          i2r_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_wdata[i2r_pkg::WIDTH_REG_W-1:0];
          i2r_pkg::REG_FRAME_HEIGHT: height_r <= cfg_wdata[i2r_pkg::HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      if (st_r == i2r_pkg::ST_WAIT && div_done) begin
        brow_r <= BR_W'(div_quot);
        bcol_r <= BC_W'(div_rem);
      end
      if (st_r == i2r_pkg::ST_BASE) begin
        tl_r <= LA_W'(brow_r * {w_eff_r, 1'b0}) + LA_W'({bcol_r, 1'b0});
      end
      if (acc && act) begin
        if (!hit || last) begin
          active_r <= 1'b0;
          pos_r    <= '0;
        end else begin
          active_r <= 1'b1;
          pos_r    <= pos_inc;
        end
        if (!hit || last || in_frame_start) begin
          brow_r <= '0;
          bcol_r <= '0;
          tl_r   <= '0;
        end else if (!is_u) begin
          if (bcol_wrap) begin
            bcol_r <= '0;
            brow_r <= brow_r + BR_W'(1);
            tl_r   <= tl_r + LA_W'(w_eff_r) + LA_W'(2);
          end else begin
            bcol_r <= bcol_r + BC_W'(1);
            tl_r   <= tl_r + LA_W'(2);
          end
        end
      end
    end
  end

  // Derived sizes, rebuilt during the settle sequence
  always_ff @(posedge clk) begin
    if (st_r == i2r_pkg::ST_SIZE) begin
      w_eff_r <= W_W'(w_lim);
      h_eff_r <= H_W'(h_lim);
    end
    if (st_r == i2r_pkg::ST_MUL) luma_n_r <= LN_W'(w_eff_r * h_eff_r);
    if (st_r == i2r_pkg::ST_BOUND) begin
      uv_bound_r <= POS_W'(luma_n_r) + POS_W'(luma_n_r >> 2);
      total_r    <= POS_W'(luma_n_r) + POS_W'(luma_n_r >> 1);
    end
  end

endmodule

/* hw/rtl/i2r_back.sv */
// ----------------------------------------------------------------------------
// I420 to RGBA converter: back end
// Owns the luma and U stores, expands each V word into four pixels and
// converts them through a short pipeline into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2r_back #(
  parameter int unsigned MAX_WIDTH  = i2r_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = i2r_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned W_W  = $clog2(MAX_WIDTH + 1),
  localparam int unsigned LA_W = i2r_pkg::idx_bits(MAX_WIDTH * MAX_HEIGHT),
  localparam int unsigned CA_W = i2r_pkg::idx_bits((MAX_WIDTH / 2) * (MAX_HEIGHT / 2)),
  localparam int unsigned BR_W = i2r_pkg::idx_bits(MAX_HEIGHT / 2),
  localparam int unsigned BC_W = i2r_pkg::idx_bits(MAX_WIDTH / 2)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  i2r_pkg::item_ctrl_t q_ctrl,
  input  logic [7:0]          q_data,
  input  logic [LA_W-1:0]     q_luma,
  input  logic [CA_W-1:0]     q_chroma,
  input  logic [BR_W-1:0]     q_brow,
  input  logic [BC_W-1:0]     q_bcol,
  output logic                q_pop,
  input  logic [W_W-1:0]      frame_w,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_pixel_rgba,
  output logic [i2r_pkg::ROW_OUT_W-1:0] out_pixel_row,
  output logic [i2r_pkg::COL_OUT_W-1:0] out_pixel_col,
  output logic                out_quad_last,
  output logic                out_frame_end
);

  localparam int unsigned LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CHROMA_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int unsigned ROW_W = BR_W + 1;
  localparam int unsigned COL_W = BC_W + 1;
  localparam int unsigned RO_W  = (ROW_W > i2r_pkg::ROW_OUT_W) ? ROW_W : i2r_pkg::ROW_OUT_W;
  localparam int unsigned CO_W  = (COL_W > i2r_pkg::COL_OUT_W) ? COL_W : i2r_pkg::COL_OUT_W;

  logic [7:0] luma_mem   [LUMA_DEPTH];
  logic [7:0] chroma_mem [CHROMA_DEPTH];

  logic             adv, issue, is_v;
  logic [1:0]       k_r;
  logic [LA_W-1:0]  rd_addr;

  // Stage 1: store read data
  logic             s1_v_r, s1_first_r, s1_qlast_r, s1_fend_r;
  logic [7:0]       s1_vbyte_r, luma_rd_r, chroma_rd_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;

  // Stage 2: chroma terms and luma
  logic               s2_v_r, s2_qlast_r, s2_fend_r;
  logic [7:0]         s2_y_r;
  logic signed [9:0]  rt_r, gt_r, bt_r;
  logic [ROW_W-1:0]   s2_row_r;
  logic [COL_W-1:0]   s2_col_r;

  // Output register
  logic               out_valid_r, out_qlast_r, out_fend_r;
  logic [7:0]         out_r_r, out_g_r, out_b_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [RO_W-1:0]    row_ext;
  logic [CO_W-1:0]    col_ext;

  logic signed [7:0]  u_s, v_s;
  logic signed [17:0] p_rv, p_gu, p_gv, p_bu, p_g;
  logic signed [17:0] sh_r, sh_g, sh_b;
  logic signed [10:0] y_s, sum_r, sum_g, sum_b;

  function automatic logic [7:0] clamp_u8(input logic signed [10:0] x);
    logic [7:0] c;
    if (x < 0) c = '0;
    else if (x > 11'sd255) c = i2r_pkg::PIX_MAX;
    else c = x[7:0];
    return c;
  endfunction

  assign adv   = !out_valid_r || !out_stall;
  assign issue = adv && q_valid;
  assign is_v  = q_ctrl.kind == i2r_pkg::ITEM_V;
  assign q_pop = issue && (!is_v || k_r == 2'd3);

  assign rd_addr = q_luma + (k_r[1] ? LA_W'(frame_w) : '0) + LA_W'(k_r[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= '0;
    else if (issue && is_v) k_r <= k_r + 2'd1;
  end

  // Stores: Y and U words write, V words read
  always_ff @(posedge clk) begin
    if (issue) begin
      case (q_ctrl.kind)
        i2r_pkg::ITEM_Y: luma_mem[q_luma] <= q_data;
        i2r_pkg::ITEM_U: chroma_mem[q_chroma] <= q_data;
        default: ;
      endcase
    end
    if (issue && is_v) luma_rd_r <= luma_mem[rd_addr];
    if (issue && is_v && k_r == 2'd0) chroma_rd_r <= chroma_mem[q_chroma];
  end

  always_ff @(posedge clk) begin
    if (issue && is_v) begin
      s1_first_r <= k_r == 2'd0;
      s1_vbyte_r <= q_data;
      s1_row_r   <= {q_brow, k_r[1]};
      s1_col_r   <= {q_bcol, k_r[0]};
      s1_qlast_r <= k_r == 2'd3;
      s1_fend_r  <= (k_r == 2'd3) && q_ctrl.frame_last;
    end
  end

  // Chroma terms, floor of the 8.8 products
  always_comb begin
    u_s  = {~chroma_rd_r[7], chroma_rd_r[6:0]};
    v_s  = {~s1_vbyte_r[7], s1_vbyte_r[6:0]};
    p_rv = 18'(v_s) * $signed(18'(i2r_pkg::COEF_RV));
    p_gu = 18'(u_s) * $signed(18'(i2r_pkg::COEF_GU));
    p_gv = 18'(v_s) * $signed(18'(i2r_pkg::COEF_GV));
    p_bu = 18'(u_s) * $signed(18'(i2r_pkg::COEF_BU));
    p_g  = p_gu + p_gv;
    sh_r = p_rv >>> 8;
    sh_g = p_g >>> 8;
    sh_b = p_bu >>> 8;
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      s2_y_r     <= luma_rd_r;
      s2_row_r   <= s1_row_r;
      s2_col_r   <= s1_col_r;
      s2_qlast_r <= s1_qlast_r;
      s2_fend_r  <= s1_fend_r;
      if (s1_first_r) begin
        rt_r <= sh_r[9:0];
        gt_r <= sh_g[9:0];
        bt_r <= sh_b[9:0];
      end
    end
  end

  always_comb begin
    y_s   = $signed({3'b000, s2_y_r});
    sum_r = y_s + 11'(rt_r);
    sum_g = y_s - 11'(gt_r);
    sum_b = y_s + 11'(bt_r);
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v_r) begin
      out_r_r     <= clamp_u8(sum_r);
      out_g_r     <= clamp_u8(sum_g);
      out_b_r     <= clamp_u8(sum_b);
      out_row_r   <= s2_row_r;
      out_col_r   <= s2_col_r;
      out_qlast_r <= s2_qlast_r;
      out_fend_r  <= s2_fend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= issue && is_v;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  assign row_ext        = RO_W'(out_row_r);
  assign col_ext        = CO_W'(out_col_r);
  assign out_valid      = out_valid_r;
  assign out_pixel_rgba = {i2r_pkg::ALPHA, out_b_r, out_g_r, out_r_r};
  assign out_pixel_row  = row_ext[i2r_pkg::ROW_OUT_W-1:0];
  assign out_pixel_col  = col_ext[i2r_pkg::COL_OUT_W-1:0];
  assign out_quad_last  = out_qlast_r;
  assign out_frame_end  = out_fend_r;

`ifndef NO_ASSERTIONS
  a_end_on_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_quad_last)
    else $error("frame end outside a quad's last pixel");
  a_quad_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quad_last |-> out_pixel_col[0] && out_pixel_row[0])
    else $error("quad closed on a pixel other than bottom-right");
  a_quad_held: assert property (@(posedge clk) disable iff (!rst_n)
    k_r != 2'd0 |-> q_valid && q_ctrl.kind == i2r_pkg::ITEM_V)
    else $error("V word left the queue before its quad finished");
`endif

endmodule

/* hw/rtl/i420_to_rgba_converter_core.sv */
// ----------------------------------------------------------------------------
// I420 to RGBA converter core
// Planar I420 bytes in, BT.601 full-range RGBA pixels out, four per V word.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake          Word
// in_      in         in_valid/in_stall  in_data_byte, in_frame_start
// out_     out        out_valid/out_stall out_pixel_rgba, row, col, quad_last,
//                                         frame_end
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// Y and U words are taken one per cycle while the front is not settling and the
// queue has room; each V word occupies the back end for four pixels, one luma
// read and one pixel per cycle unless out_stall holds it. With the queue empty,
// a V word passes the queue, store read, chroma terms and output register before
// out_valid rises for its first pixel. After reset and after every register
// write the input is stalled while sizes and the block position are rederived
// through the divider. cfg_ready is always high.
// out_stall holds the back end; the front keeps taking words until the
// four-entry queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i420_to_rgba_converter_core #(
  parameter int unsigned MAX_WIDTH  = i2r_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = i2r_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  // pixel stream
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_rgba,
  output logic [i2r_pkg::ROW_OUT_W-1:0] out_pixel_row,
  output logic [i2r_pkg::COL_OUT_W-1:0] out_pixel_col,
  output logic        out_quad_last,
  output logic        out_frame_end,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [i2r_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned W_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LA_W = i2r_pkg::idx_bits(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned CA_W = i2r_pkg::idx_bits((MAX_WIDTH / 2) * (MAX_HEIGHT / 2));
  localparam int unsigned BR_W = i2r_pkg::idx_bits(MAX_HEIGHT / 2);
  localparam int unsigned BC_W = i2r_pkg::idx_bits(MAX_WIDTH / 2);
  localparam int unsigned Q_W  = $bits(i2r_pkg::item_ctrl_t) + 8 + LA_W + CA_W + BR_W + BC_W;

  // Front to queue
  logic                push, q_full;
  i2r_pkg::item_ctrl_t push_ctrl;
  logic [7:0]          push_data;
  logic [LA_W-1:0]     push_luma;
  logic [CA_W-1:0]     push_chroma;
  logic [BR_W-1:0]     push_brow;
  logic [BC_W-1:0]     push_bcol;
  logic [Q_W-1:0]      push_word;

  // Queue to back
  logic                q_pop, q_empty;
  logic [Q_W-1:0]      pop_word;
  i2r_pkg::item_ctrl_t q_ctrl;
  logic [7:0]          q_data;
  logic [LA_W-1:0]     q_luma;
  logic [CA_W-1:0]     q_chroma;
  logic [BR_W-1:0]     q_brow;
  logic [BC_W-1:0]     q_bcol;
  logic [W_W-1:0]      frame_w;

  // Registers are always writable; the front restarts its settle sequence
  assign cfg_ready = 1'b1;

  i2r_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .push_ctrl      (push_ctrl),
    .push_data      (push_data),
    .push_luma      (push_luma),
    .push_chroma    (push_chroma),
    .push_brow      (push_brow),
    .push_bcol      (push_bcol),
    .q_full         (q_full),
    .frame_w        (frame_w)
  );

  assign push_word = {push_ctrl, push_data, push_luma, push_chroma, push_brow, push_bcol};

  i2r_queue #(
    .DATA_W(Q_W),
    .DEPTH (i2r_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_word),
    .empty     (q_empty)
  );

  assign {q_ctrl, q_data, q_luma, q_chroma, q_brow, q_bcol} = pop_word;

  i2r_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (!q_empty),
    .q_ctrl         (q_ctrl),
    .q_data         (q_data),
    .q_luma         (q_luma),
    .q_chroma       (q_chroma),
    .q_brow         (q_brow),
    .q_bcol         (q_bcol),
    .q_pop          (q_pop),
    .frame_w        (frame_w),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_rgba (out_pixel_rgba),
    .out_pixel_row  (out_pixel_row),
    .out_pixel_col  (out_pixel_col),
    .out_quad_last  (out_quad_last),
    .out_frame_end  (out_frame_end)
  );

endmodule
